[design/assert_macros.svh]
// Assertion macros for the grouped decimal text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BDAG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BDAG_ASSERT_NEVER(label, cond) \
    `BDAG_ASSERT(label, !(cond))
`else
`define BDAG_ASSERT(label, prop)
`define BDAG_ASSERT_NEVER(label, cond)
`endif
`endif

[design/bdag_pkg.sv]
// Shared widths and character codes for the grouped decimal text converter.
package bdag_pkg;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 7;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_COMMA = 8'h2C;
    localparam logic [DIGIT_W-1:0] DAB_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] DAB_ADJ    = 4'd3;
endpackage

[design/binary_to_decimal_ascii_grouped.sv]
// Top level: 64-bit unsigned value to comma-grouped decimal ASCII text.
// It shifts in one input bit per cycle to form BCD digits, hands them to the
// emitter, then scans one digit slot per cycle (MAX_DIGITS, leading zeros skipped
// silently), pausing the scan for each comma. The block stays busy until the scan
// is through, so a new word is taken only then; the rate is set by the
// one-bit-per-cycle BCD shift loop and digit scan.
// Reset (rst_n, async, active low) clears all control; the receiver cannot stall.
`include "assert_macros.svh"
module binary_to_decimal_ascii_grouped
    import bdag_pkg::*;
#(
    parameter int MAX_DIGITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               valid,
    output logic [CHAR_W-1:0]  char_code,
    output logic               last
);
    logic                          accept;
    logic                          conv_active;
    logic                          conv_done;
    logic [DIGIT_W*MAX_DIGITS-1:0] conv_bcd;
    logic                          emit_active;

    // a word is taken only when both converter and emitter are quiet
    assign accept = start && !busy;
    assign busy   = conv_active | emit_active;

    // stage 1: double-dabble, one input bit per cycle into MAX_DIGITS BCD digits
    bdag_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .value  (value),
        .active (conv_active),
        .done   (conv_done),
        .bcd    (conv_bcd)
    );

    // stage 2: scan digits top down, one per cycle, pausing at each comma; output register decouples
    // the final character from the next word's acceptance
    bdag_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (conv_done),
        .bcd       (conv_bcd),
        .active    (emit_active),
        .valid     (valid),
        .char_code (char_code),
        .last      (last)
    );

    // a comma is never the final character
    `BDAG_ASSERT_NEVER(a_last_not_comma, valid && last && char_code == CHAR_COMMA)
    // once text has begun it runs without gaps until the last character
    `BDAG_ASSERT(a_no_gap, valid && !last |=> valid)
    // two commas never come back to back
    `BDAG_ASSERT(a_comma_then_digit, valid && char_code == CHAR_COMMA |=> char_code != CHAR_COMMA)
    // an accepted word makes the block busy
    `BDAG_ASSERT(a_accept_busy, accept |=> busy)
endmodule

[design/bdag_dabble.sv]
// Bit-serial shift-and-add-3 binary to BCD converter.
module bdag_dabble
    import bdag_pkg::*;
#(
    parameter int MAX_DIGITS = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [VALUE_W-1:0]            value,
    output logic                          active,
    output logic                          done,
    output logic [DIGIT_W*MAX_DIGITS-1:0] bcd
);
    localparam int BCD_W = DIGIT_W * MAX_DIGITS;
    localparam logic [COUNT_W-1:0] LAST_BIT = COUNT_W'(VALUE_W - 1);

    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next, bcd_adj;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    // add 3 to every digit of five or more before the doubling shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DAB_LIMIT)
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DAB_ADJ;
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (load)
        begin
            shift_next = value;
            bcd_next   = '0;
            count_next = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            // carry out of the top digit is dropped: result is modulo 10^MAX_DIGITS
            bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
            shift_next = shift_reg << 1;
            count_next = count_reg + COUNT_W'(1);
            if (count_reg == LAST_BIT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg   <= '0;
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            bcd_reg   <= bcd_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign active = run_reg | done_reg;
    assign done   = done_reg;
    assign bcd    = bcd_reg;
endmodule

[design/bdag_emit.sv]
// Digit-serial emitter: leading zero skip, comma grouping, ASCII output.
module bdag_emit
    import bdag_pkg::*;
#(
    parameter int MAX_DIGITS = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [DIGIT_W*MAX_DIGITS-1:0] bcd,
    output logic                          active,
    output logic                          valid,
    output logic [CHAR_W-1:0]             char_code,
    output logic                          last
);
    localparam int BCD_W = DIGIT_W * MAX_DIGITS;
    localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [POS_W-1:0] TOP_POS   = POS_W'(MAX_DIGITS - 1);
    localparam logic [1:0]       TOP_PHASE = 2'((MAX_DIGITS - 1) % 3);
    localparam logic [1:0]       PHASE_MAX = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_DIGIT, ST_COMMA} state_t;

    state_t             state_reg, state_next;
    logic [BCD_W-1:0]   digits_reg, digits_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         phase_reg, phase_next;
    logic               started_reg, started_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic [DIGIT_W-1:0] top_digit;

    assign top_digit = digits_reg[BCD_W-1 -: DIGIT_W];

    always_comb
    begin
        state_next   = state_reg;
        digits_next  = digits_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        started_next = started_reg;
        valid_next   = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    digits_next  = bcd;
                    pos_next     = TOP_POS;
                    phase_next   = TOP_PHASE;
                    started_next = 1'b0;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                digits_next = digits_reg << DIGIT_W;
                pos_next    = pos_reg - POS_W'(1);
                phase_next  = (phase_reg == 2'd0) ? PHASE_MAX : phase_reg - 2'd1;
                if (started_reg || top_digit != '0 || pos_reg == '0)
                begin
                    started_next = 1'b1;
                    valid_next   = 1'b1;
                    char_next    = CHAR_ZERO + CHAR_W'(top_digit);
                    if (pos_reg == '0)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (phase_reg == 2'd0)
                        state_next = ST_COMMA;
                end
            end
            ST_COMMA:
            begin
                valid_next = 1'b1;
                char_next  = CHAR_COMMA;
                state_next = ST_DIGIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
            pos_reg     <= '0;
            phase_reg   <= '0;
            digits_reg  <= '0;
            char_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            digits_reg  <= digits_next;
            char_reg    <= char_next;
        end
    end

    assign active    = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
endmodule
